[sv/c8eu_pkg.sv]
// ---------------------------------------------------------------------------
// c8eu_pkg: shared types for the 8-bit execute unit
// Operation codes, branch test selectors and the stack page bit.
// ---------------------------------------------------------------------------
package c8eu_pkg;

    typedef enum logic [5:0] {
        CMD_LDA = 6'd0,  CMD_LDX = 6'd1,  CMD_LDY = 6'd2,  CMD_STA = 6'd3,
        CMD_STX = 6'd4,  CMD_STY = 6'd5,  CMD_TAX = 6'd6,  CMD_TXA = 6'd7,
        CMD_TAY = 6'd8,  CMD_TYA = 6'd9,  CMD_TSX = 6'd10, CMD_TXS = 6'd11,
        CMD_ADC = 6'd12, CMD_SBC = 6'd13, CMD_AND = 6'd14, CMD_ORA = 6'd15,
        CMD_EOR = 6'd16, CMD_CMP = 6'd17, CMD_CPX = 6'd18, CMD_CPY = 6'd19,
        CMD_BIT = 6'd20, CMD_ASL = 6'd21, CMD_LSR = 6'd22, CMD_ROL = 6'd23,
        CMD_ROR = 6'd24, CMD_INC = 6'd25, CMD_DEC = 6'd26, CMD_INX = 6'd27,
        CMD_DEX = 6'd28, CMD_INY = 6'd29, CMD_DEY = 6'd30, CMD_CLC = 6'd31,
        CMD_SEC = 6'd32, CMD_CLI = 6'd33, CMD_SEI = 6'd34, CMD_CLD = 6'd35,
        CMD_SED = 6'd36, CMD_CLV = 6'd37, CMD_PHA = 6'd38, CMD_PHP = 6'd39,
        CMD_PLA = 6'd40, CMD_PLP = 6'd41, CMD_BRT = 6'd42, CMD_NOP = 6'd43
    } t_cmd;

    typedef enum logic [2:0] {
        BR_CC = 3'd0, BR_CS = 3'd1, BR_EQ = 3'd2, BR_MI = 3'd3,
        BR_NE = 3'd4, BR_PL = 3'd5, BR_VC = 3'd6, BR_VS = 3'd7
    } t_branch;

    // high bit of every stack page address
    localparam logic STACK_PAGE_BIT = 1'b1;

endpackage

[sv/cpu8_execute_unit_with_flags.sv]
// ---------------------------------------------------------------------------
// cpu8_execute_unit_with_flags: execute stage of an 8-bit 6502-style core
// Holds A, X, Y, SP and the C Z I D V N flags; runs one decoded operation
// per transfer and reports the memory/stack write, branch test and state.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------------
//  input    | in        | i_valid / o_stall | i_cmd, i_operand,
//           |           |                   | i_on_accumulator, i_branch_condition
//  result   | out       | o_valid / i_stall | o_write_data .. o_sp_out
//
//  One item per cycle while the result side does not stall; an input item
//  passes the input register, then the ALU into the result register, where
//  it is offered and transfers once the receiver does not stall.
//  Architectural registers update as an item moves into the result register,
//  so the next item sees them at once.
//  Reset clears all registers and flags, sets I, and empties both stages.
//  A stalled result holds; the input register keeps taking items while the
//  result register is free or being drained.
// ---------------------------------------------------------------------------
module cpu8_execute_unit_with_flags (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [5:0] i_cmd,
    input  logic [7:0] i_operand,
    input  logic       i_on_accumulator,
    input  logic [2:0] i_branch_condition,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_write_data,
    output logic       o_write_valid,
    output logic [8:0] o_stack_address,
    output logic       o_branch_taken,
    output logic [7:0] o_status_byte,
    output logic [7:0] o_acc_out,
    output logic [7:0] o_x_out,
    output logic [7:0] o_y_out,
    output logic [7:0] o_sp_out
);

    // input register
    logic                r_in_valid;
    c8eu_pkg::t_cmd      r_in_cmd;
    logic [7:0]          r_in_operand;
    logic                r_in_on_acc;
    c8eu_pkg::t_branch   r_in_cond;

    // architectural state
    logic [7:0] r_a, r_x, r_y, r_sp;
    logic       r_c, r_z, r_i, r_d, r_v, r_n;
    logic [7:0] n_a, n_x, n_y, n_sp;
    logic       n_c, n_z, n_i, n_d, n_v, n_n;

    // result register
    logic       r_out_valid;
    logic [7:0] r_wdata;
    logic       r_wvalid;
    logic [8:0] r_saddr;
    logic       r_taken;
    logic [7:0] n_wdata;
    logic       n_wvalid;
    logic [8:0] n_saddr;
    logic       n_taken;

    logic       out_free;
    logic       move;
    logic       in_take;

    // datapath helpers
    logic [7:0] m;
    logic [7:0] adc_m;
    logic [8:0] adc_sum;
    logic [7:0] cmp_reg;
    logic [8:0] cmp_diff;
    logic [7:0] sh_src;
    logic [7:0] sh_res;
    logic       sh_c;
    logic       set_zn;
    logic [7:0] zn_val;
    logic       stack_touched;
    logic [7:0] php_byte;

    assign out_free = !r_out_valid || !i_stall;
    assign move     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    assign m        = r_in_operand;
    assign adc_m    = (r_in_cmd == c8eu_pkg::CMD_SBC) ? ~m : m;
    assign adc_sum  = {1'b0, r_a} + {1'b0, adc_m} + {8'd0, r_c};
    assign cmp_reg  = (r_in_cmd == c8eu_pkg::CMD_CPX) ? r_x :
                      (r_in_cmd == c8eu_pkg::CMD_CPY) ? r_y : r_a;
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};
    assign sh_src   = r_in_on_acc ? r_a : m;
    assign php_byte = {r_n, r_v, 2'b11, r_d, r_i, r_z, r_c};

    always_comb begin
        case (r_in_cmd)
            c8eu_pkg::CMD_ASL: begin
                sh_c   = sh_src[7];
                sh_res = {sh_src[6:0], 1'b0};
            end
            c8eu_pkg::CMD_ROL: begin
                sh_c   = sh_src[7];
                sh_res = {sh_src[6:0], r_c};
            end
            c8eu_pkg::CMD_ROR: begin
                sh_c   = sh_src[0];
                sh_res = {r_c, sh_src[7:1]};
            end
            default: begin
                sh_c   = sh_src[0];
                sh_res = {1'b0, sh_src[7:1]};
            end
        endcase
    end

    always_comb begin
        n_a = r_a;  n_x = r_x;  n_y = r_y;  n_sp = r_sp;
        n_c = r_c;  n_z = r_z;  n_i = r_i;  n_d = r_d;  n_v = r_v;  n_n = r_n;
        n_wdata       = 8'd0;
        n_wvalid      = 1'b0;
        n_taken       = 1'b0;
        n_saddr       = 9'd0;
        stack_touched = 1'b0;
        set_zn        = 1'b0;
        zn_val        = 8'd0;
        case (r_in_cmd)
            c8eu_pkg::CMD_LDA: begin n_a = m; set_zn = 1'b1; zn_val = m; end
            c8eu_pkg::CMD_LDX: begin n_x = m; set_zn = 1'b1; zn_val = m; end
            c8eu_pkg::CMD_LDY: begin n_y = m; set_zn = 1'b1; zn_val = m; end
            c8eu_pkg::CMD_STA: begin n_wdata = r_a; n_wvalid = 1'b1; end
            c8eu_pkg::CMD_STX: begin n_wdata = r_x; n_wvalid = 1'b1; end
            c8eu_pkg::CMD_STY: begin n_wdata = r_y; n_wvalid = 1'b1; end
            c8eu_pkg::CMD_TAX: begin n_x = r_a; set_zn = 1'b1; zn_val = r_a; end
            c8eu_pkg::CMD_TXA: begin n_a = r_x; set_zn = 1'b1; zn_val = r_x; end
            c8eu_pkg::CMD_TAY: begin n_y = r_a; set_zn = 1'b1; zn_val = r_a; end
            c8eu_pkg::CMD_TYA: begin n_a = r_y; set_zn = 1'b1; zn_val = r_y; end
            c8eu_pkg::CMD_TSX: begin n_x = r_sp; set_zn = 1'b1; zn_val = r_sp; end
            c8eu_pkg::CMD_TXS: begin n_sp = r_x; end
            c8eu_pkg::CMD_ADC, c8eu_pkg::CMD_SBC: begin
                n_a    = adc_sum[7:0];
                n_c    = adc_sum[8];
                n_v    = (r_a[7] ^ adc_sum[7]) & (adc_m[7] ^ adc_sum[7]);
                set_zn = 1'b1;
                zn_val = adc_sum[7:0];
            end
            c8eu_pkg::CMD_AND: begin
                n_a = r_a & m; set_zn = 1'b1; zn_val = r_a & m;
            end
            c8eu_pkg::CMD_ORA: begin
                n_a = r_a | m; set_zn = 1'b1; zn_val = r_a | m;
            end
            c8eu_pkg::CMD_EOR: begin
                n_a = r_a ^ m; set_zn = 1'b1; zn_val = r_a ^ m;
            end
            c8eu_pkg::CMD_CMP, c8eu_pkg::CMD_CPX, c8eu_pkg::CMD_CPY: begin
                n_z = (cmp_reg == m);
                n_n = cmp_diff[7];
                n_c = !cmp_diff[8];
            end
            c8eu_pkg::CMD_BIT: begin
                n_z = ((m & r_a) == 8'd0);
                n_n = m[7];
                n_v = m[6];
            end
            c8eu_pkg::CMD_ASL, c8eu_pkg::CMD_LSR,
            c8eu_pkg::CMD_ROL, c8eu_pkg::CMD_ROR: begin
                n_c    = sh_c;
                set_zn = 1'b1;
                zn_val = sh_res;
                if (r_in_on_acc) begin
                    n_a = sh_res;
                end else begin
                    n_wdata  = sh_res;
                    n_wvalid = 1'b1;
                end
            end
            c8eu_pkg::CMD_INC: begin
                n_wdata = m + 8'd1; n_wvalid = 1'b1;
                set_zn = 1'b1; zn_val = m + 8'd1;
            end
            c8eu_pkg::CMD_DEC: begin
                n_wdata = m - 8'd1; n_wvalid = 1'b1;
                set_zn = 1'b1; zn_val = m - 8'd1;
            end
            c8eu_pkg::CMD_INX: begin
                n_x = r_x + 8'd1; set_zn = 1'b1; zn_val = r_x + 8'd1;
            end
            c8eu_pkg::CMD_DEX: begin
                n_x = r_x - 8'd1; set_zn = 1'b1; zn_val = r_x - 8'd1;
            end
            c8eu_pkg::CMD_INY: begin
                n_y = r_y + 8'd1; set_zn = 1'b1; zn_val = r_y + 8'd1;
            end
            c8eu_pkg::CMD_DEY: begin
                n_y = r_y - 8'd1; set_zn = 1'b1; zn_val = r_y - 8'd1;
            end
            c8eu_pkg::CMD_CLC: n_c = 1'b0;
            c8eu_pkg::CMD_SEC: n_c = 1'b1;
            c8eu_pkg::CMD_CLI: n_i = 1'b0;
            c8eu_pkg::CMD_SEI: n_i = 1'b1;
            c8eu_pkg::CMD_CLD: n_d = 1'b0;
            c8eu_pkg::CMD_SED: n_d = 1'b1;
            c8eu_pkg::CMD_CLV: n_v = 1'b0;
            c8eu_pkg::CMD_PHA, c8eu_pkg::CMD_PHP: begin
                // push: write at the current SP, then decrement
                n_wdata       = (r_in_cmd == c8eu_pkg::CMD_PHA) ? r_a : php_byte;
                n_wvalid      = 1'b1;
                stack_touched = 1'b1;
                n_saddr       = {c8eu_pkg::STACK_PAGE_BIT, r_sp};
                n_sp          = r_sp - 8'd1;
            end
            c8eu_pkg::CMD_PLA, c8eu_pkg::CMD_PLP: begin
                n_sp          = r_sp + 8'd1;
                stack_touched = 1'b1;
                n_saddr       = {c8eu_pkg::STACK_PAGE_BIT, r_sp + 8'd1};
                if (r_in_cmd == c8eu_pkg::CMD_PLA) begin
                    n_a    = m;
                    set_zn = 1'b1;
                    zn_val = m;
                end else begin
                    // bits 4 and 5 of the pulled byte are dropped
                    n_c = m[0]; n_z = m[1]; n_i = m[2];
                    n_d = m[3]; n_v = m[6]; n_n = m[7];
                end
            end
            c8eu_pkg::CMD_BRT: begin
                case (r_in_cond)
                    c8eu_pkg::BR_CC: n_taken = !r_c;
                    c8eu_pkg::BR_CS: n_taken = r_c;
                    c8eu_pkg::BR_EQ: n_taken = r_z;
                    c8eu_pkg::BR_MI: n_taken = r_n;
                    c8eu_pkg::BR_NE: n_taken = !r_z;
                    c8eu_pkg::BR_PL: n_taken = !r_n;
                    c8eu_pkg::BR_VC: n_taken = !r_v;
                    c8eu_pkg::BR_VS: n_taken = r_v;
                    default:         n_taken = 1'b0;
                endcase
            end
            default: ;
        endcase
        if (set_zn) begin
            n_z = (zn_val == 8'd0);
            n_n = zn_val[7];
        end
        if (!stack_touched) begin
            n_saddr = {c8eu_pkg::STACK_PAGE_BIT, n_sp};
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (in_take) begin
            r_in_cmd     <= c8eu_pkg::t_cmd'(i_cmd);
            r_in_operand <= i_operand;
            r_in_on_acc  <= i_on_accumulator;
            r_in_cond    <= c8eu_pkg::t_branch'(i_branch_condition);
        end
    end

    // architectural state advances with each item moved to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= 8'd0;  r_x <= 8'd0;  r_y <= 8'd0;  r_sp <= 8'd0;
            r_c <= 1'b0;  r_z <= 1'b0;  r_i <= 1'b1;  r_d  <= 1'b0;
            r_v <= 1'b0;  r_n <= 1'b0;
        end else if (move) begin
            r_a <= n_a;  r_x <= n_x;  r_y <= n_y;  r_sp <= n_sp;
            r_c <= n_c;  r_z <= n_z;  r_i <= n_i;  r_d  <= n_d;
            r_v <= n_v;  r_n <= n_n;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (move) begin
            r_wdata  <= n_wdata;
            r_wvalid <= n_wvalid;
            r_saddr  <= n_saddr;
            r_taken  <= n_taken;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_write_data    = r_wdata;
    assign o_write_valid   = r_wvalid;
    assign o_stack_address = r_saddr;
    assign o_branch_taken  = r_taken;
    assign o_status_byte   = {r_n, r_v, 1'b1, 1'b0, r_d, r_i, r_z, r_c};
    assign o_acc_out       = r_a;
    assign o_x_out         = r_x;
    assign o_y_out         = r_y;
    assign o_sp_out        = r_sp;

    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_valid |-> o_write_data == 8'd0)
        else $error("write data not zero without a write");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_in_cmd) && $stable(r_in_operand))
        else $error("stalled input register changed");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !move |=> $stable(r_a) && $stable(r_sp) && $stable(o_status_byte))
        else $error("state changed without an item");

    a_stack_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stack_address[8])
        else $error("stack address off the stack page");

    a_reset_irq: assert property (@(posedge i_clk)
        !i_rst_n |=> r_i && !r_out_valid && !r_in_valid)
        else $error("reset state wrong");

endmodule

[verif/cpu8_execute_unit_with_flags_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpu8_execute_unit_with_flags_tb: self-checking bench for the execute unit
// Drives decoded operations through the valid/stall input channel, mirrors
// A, X, Y, SP and the flags in a local model, and checks every field of each
// result transfer in order. Both sides insert random idle bursts.
// ---------------------------------------------------------------------------
module cpu8_execute_unit_with_flags_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int RESULT_LATENCY = 2;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 40;
    localparam logic [5:0] CMD_UNUSED_LO = c8eu_pkg::CMD_NOP + 6'd1;
    localparam logic [5:0] CMD_UNUSED_HI = 6'h3f;
    localparam logic [7:0] PUSHED_B_BITS = 8'h10;

    typedef struct packed {
        logic [7:0] write_data;
        logic       write_valid;
        logic [8:0] stack_address;
        logic       branch_taken;
        logic [7:0] status_byte;
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
    } t_exec_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [5:0] i_cmd = c8eu_pkg::CMD_NOP;
    logic [7:0] i_operand = 8'h00;
    logic       i_on_accumulator = 1'b0;
    logic [2:0] i_branch_condition = c8eu_pkg::BR_CC;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_write_data;
    logic       o_write_valid;
    logic [8:0] o_stack_address;
    logic       o_branch_taken;
    logic [7:0] o_status_byte;
    logic [7:0] o_acc_out;
    logic [7:0] o_x_out;
    logic [7:0] o_y_out;
    logic [7:0] o_sp_out;

    // Local copy of the architectural state
    logic [7:0] reg_a, reg_x, reg_y, reg_sp;
    logic       flag_c, flag_z, flag_i, flag_d, flag_v, flag_n;

    t_exec_result pending_results[$];
    logic [63:0]  cmd_seen = '0;
    int           ops_sent = 0;
    int           results_checked = 0;
    int           error_count = 0;
    int           idle_cycles = 0;
    int           stall_left = 0;
    bit           idle_on = 1'b0;

    cpu8_execute_unit_with_flags DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_cmd              (i_cmd),
        .i_operand          (i_operand),
        .i_on_accumulator   (i_on_accumulator),
        .i_branch_condition (i_branch_condition),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_write_data       (o_write_data),
        .o_write_valid      (o_write_valid),
        .o_stack_address    (o_stack_address),
        .o_branch_taken     (o_branch_taken),
        .o_status_byte      (o_status_byte),
        .o_acc_out          (o_acc_out),
        .o_x_out            (o_x_out),
        .o_y_out            (o_y_out),
        .o_sp_out           (o_sp_out)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Execute model
    // ------------------------------------------------------------------
    function automatic logic [7:0] packed_status();
        return {flag_n, flag_v, 1'b1, 1'b0, flag_d, flag_i, flag_z, flag_c};
    endfunction

    function automatic void set_zn(input logic [7:0] v);
        flag_z = (v == 8'h00);
        flag_n = v[7];
    endfunction

    function automatic void compare_flags(input logic [7:0] r, input logic [7:0] m);
        logic [7:0] diff;
        diff   = r - m;
        flag_z = (r == m);
        flag_n = diff[7];
        flag_c = (r >= m);
    endfunction

    function automatic void clear_state();
        reg_a  = 8'h00;
        reg_x  = 8'h00;
        reg_y  = 8'h00;
        reg_sp = 8'h00;
        flag_c = 1'b0;
        flag_z = 1'b0;
        flag_i = 1'b1;
        flag_d = 1'b0;
        flag_v = 1'b0;
        flag_n = 1'b0;
    endfunction

    function automatic t_exec_result execute_op(input logic [5:0] cmd, input logic [7:0] m,
                                                input logic on_acc, input logic [2:0] cond);
        t_exec_result r;
        logic [8:0]   sum;
        logic [7:0]   addend, src, shifted;
        logic [8:0]   saddr;
        logic         touched;
        r       = '0;
        touched = 1'b0;
        saddr   = '0;
        case (cmd)
            c8eu_pkg::CMD_LDA: begin reg_a = m; set_zn(m); end
            c8eu_pkg::CMD_LDX: begin reg_x = m; set_zn(m); end
            c8eu_pkg::CMD_LDY: begin reg_y = m; set_zn(m); end
            c8eu_pkg::CMD_STA: begin r.write_data = reg_a; r.write_valid = 1'b1; end
            c8eu_pkg::CMD_STX: begin r.write_data = reg_x; r.write_valid = 1'b1; end
            c8eu_pkg::CMD_STY: begin r.write_data = reg_y; r.write_valid = 1'b1; end
            c8eu_pkg::CMD_TAX: begin reg_x = reg_a; set_zn(reg_x); end
            c8eu_pkg::CMD_TXA: begin reg_a = reg_x; set_zn(reg_a); end
            c8eu_pkg::CMD_TAY: begin reg_y = reg_a; set_zn(reg_y); end
            c8eu_pkg::CMD_TYA: begin reg_a = reg_y; set_zn(reg_a); end
            c8eu_pkg::CMD_TSX: begin reg_x = reg_sp; set_zn(reg_x); end
            c8eu_pkg::CMD_TXS: reg_sp = reg_x;
            c8eu_pkg::CMD_ADC, c8eu_pkg::CMD_SBC: begin
                // subtract is add of the inverted operand, binary only
                addend  = (cmd == c8eu_pkg::CMD_SBC) ? ~m : m;
                sum     = {1'b0, reg_a} + {1'b0, addend} + {8'h00, flag_c};
                flag_c  = sum[8];
                flag_v  = (reg_a[7] ^ sum[7]) & (addend[7] ^ sum[7]);
                reg_a   = sum[7:0];
                set_zn(reg_a);
            end
            c8eu_pkg::CMD_AND: begin reg_a = reg_a & m; set_zn(reg_a); end
            c8eu_pkg::CMD_ORA: begin reg_a = reg_a | m; set_zn(reg_a); end
            c8eu_pkg::CMD_EOR: begin reg_a = reg_a ^ m; set_zn(reg_a); end
            c8eu_pkg::CMD_CMP: compare_flags(reg_a, m);
            c8eu_pkg::CMD_CPX: compare_flags(reg_x, m);
            c8eu_pkg::CMD_CPY: compare_flags(reg_y, m);
            c8eu_pkg::CMD_BIT: begin
                flag_z = ((m & reg_a) == 8'h00);
                flag_n = m[7];
                flag_v = m[6];
            end
            c8eu_pkg::CMD_ASL, c8eu_pkg::CMD_LSR, c8eu_pkg::CMD_ROL, c8eu_pkg::CMD_ROR: begin
                src = on_acc ? reg_a : m;
                case (cmd)
                    c8eu_pkg::CMD_ASL: begin
                        shifted = {src[6:0], 1'b0};   flag_c = src[7];
                    end
                    c8eu_pkg::CMD_LSR: begin
                        shifted = {1'b0, src[7:1]};   flag_c = src[0];
                    end
                    c8eu_pkg::CMD_ROL: begin
                        shifted = {src[6:0], flag_c}; flag_c = src[7];
                    end
                    default: begin
                        shifted = {flag_c, src[7:1]}; flag_c = src[0];
                    end
                endcase
                set_zn(shifted);
                if (on_acc) begin
                    reg_a = shifted;
                end else begin
                    r.write_data  = shifted;
                    r.write_valid = 1'b1;
                end
            end
            c8eu_pkg::CMD_INC: begin
                r.write_data = m + 8'd1; r.write_valid = 1'b1; set_zn(r.write_data);
            end
            c8eu_pkg::CMD_DEC: begin
                r.write_data = m - 8'd1; r.write_valid = 1'b1; set_zn(r.write_data);
            end
            c8eu_pkg::CMD_INX: begin reg_x = reg_x + 8'd1; set_zn(reg_x); end
            c8eu_pkg::CMD_DEX: begin reg_x = reg_x - 8'd1; set_zn(reg_x); end
            c8eu_pkg::CMD_INY: begin reg_y = reg_y + 8'd1; set_zn(reg_y); end
            c8eu_pkg::CMD_DEY: begin reg_y = reg_y - 8'd1; set_zn(reg_y); end
            c8eu_pkg::CMD_CLC: flag_c = 1'b0;
            c8eu_pkg::CMD_SEC: flag_c = 1'b1;
            c8eu_pkg::CMD_CLI: flag_i = 1'b0;
            c8eu_pkg::CMD_SEI: flag_i = 1'b1;
            c8eu_pkg::CMD_CLD: flag_d = 1'b0;
            c8eu_pkg::CMD_SED: flag_d = 1'b1;
            c8eu_pkg::CMD_CLV: flag_v = 1'b0;
            c8eu_pkg::CMD_PHA, c8eu_pkg::CMD_PHP: begin
                r.write_data  = (cmd == c8eu_pkg::CMD_PHA) ? reg_a
                                                           : (packed_status() | PUSHED_B_BITS);
                r.write_valid = 1'b1;
                touched       = 1'b1;
                saddr         = {c8eu_pkg::STACK_PAGE_BIT, reg_sp};
                reg_sp        = reg_sp - 8'd1;
            end
            c8eu_pkg::CMD_PLA, c8eu_pkg::CMD_PLP: begin
                // pull: bump SP first, operand is the byte read there
                reg_sp  = reg_sp + 8'd1;
                touched = 1'b1;
                saddr   = {c8eu_pkg::STACK_PAGE_BIT, reg_sp};
                if (cmd == c8eu_pkg::CMD_PLA) begin
                    reg_a = m;
                    set_zn(m);
                end else begin
                    flag_c = m[0];
                    flag_z = m[1];
                    flag_i = m[2];
                    flag_d = m[3];
                    flag_v = m[6];
                    flag_n = m[7];
                end
            end
            c8eu_pkg::CMD_BRT: begin
                case (cond)
                    c8eu_pkg::BR_CC: r.branch_taken = ~flag_c;
                    c8eu_pkg::BR_CS: r.branch_taken = flag_c;
                    c8eu_pkg::BR_EQ: r.branch_taken = flag_z;
                    c8eu_pkg::BR_MI: r.branch_taken = flag_n;
                    c8eu_pkg::BR_NE: r.branch_taken = ~flag_z;
                    c8eu_pkg::BR_PL: r.branch_taken = ~flag_n;
                    c8eu_pkg::BR_VC: r.branch_taken = ~flag_v;
                    default:         r.branch_taken = flag_v;
                endcase
            end
            default: ;
        endcase
        r.stack_address = touched ? saddr : {c8eu_pkg::STACK_PAGE_BIT, reg_sp};
        r.status_byte   = packed_status();
        r.acc           = reg_a;
        r.x             = reg_x;
        r.y             = reg_y;
        r.sp            = reg_sp;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t result #%0d: %s", $time, results_checked, what);
    endtask

    task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_exec_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with no operation pending");
            end else begin
                want = pending_results.pop_front();
                check_field("write_data",    9'(o_write_data),    9'(want.write_data));
                check_field("write_valid",   9'(o_write_valid),   9'(want.write_valid));
                check_field("stack_address", o_stack_address,     want.stack_address);
                check_field("branch_taken",  9'(o_branch_taken),  9'(want.branch_taken));
                check_field("status_byte",   9'(o_status_byte),   9'(want.status_byte));
                check_field("acc_out",       9'(o_acc_out),       9'(want.acc));
                check_field("x_out",         9'(o_x_out),         9'(want.x));
                check_field("y_out",         9'(o_y_out),         9'(want.y));
                check_field("sp_out",        9'(o_sp_out),        9'(want.sp));
            end
            results_checked++;
        end
    end

    // Receiver backpressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 8);
            i_stall    <= 1'b1;
        end else begin
            i_stall    <= 1'b0;
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [7:0] corner_byte(input int k);
        case (k % 5)
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h80;
            3:       return 8'h7f;
            default: return 8'h01;
        endcase
    endfunction

    task automatic send_op(input logic [5:0] cmd, input logic [7:0] opnd,
                           input logic on_acc, input logic [2:0] cond);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_cmd              <= cmd;
        i_operand          <= opnd;
        i_on_accumulator   <= on_acc;
        i_branch_condition <= cond;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(execute_op(cmd, opnd, on_acc, cond));
        cmd_seen[cmd] = 1'b1;
        ops_sent++;
    endtask

    task automatic send_random_op();
        logic [5:0] cmd;
        logic [7:0] opnd;
        if ($urandom_range(0, 19) == 0)
            cmd = 6'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else
            cmd = 6'($urandom_range(c8eu_pkg::CMD_LDA, c8eu_pkg::CMD_NOP));
        opnd = ($urandom_range(0, 3) == 0) ? corner_byte($urandom_range(0, 4))
                                           : 8'($urandom_range(0, 255));
        send_op(cmd, opnd, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_every_operation();
        for (int c = c8eu_pkg::CMD_LDA; c <= c8eu_pkg::CMD_NOP; c++)
            send_op(6'(c), corner_byte(c), 1'(c), 3'(c));
    endtask

    task automatic test_special_cases();
        // pushed status shows bits 4 and 5; pulled status ignores them
        send_op(c8eu_pkg::CMD_SEC, 8'h00, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_SED, 8'h00, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_PHP, 8'h00, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_PLP, 8'h30, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_PLP, 8'hcf, 1'b1, c8eu_pkg::BR_VS);
        send_op(c8eu_pkg::CMD_PHP, 8'h00, 1'b0, c8eu_pkg::BR_CC);
        // wrap SP both ways
        send_op(c8eu_pkg::CMD_LDX, 8'hff, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_TXS, 8'h00, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_PLA, 8'h80, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_PHA, 8'h00, 1'b0, c8eu_pkg::BR_CC);
        // signed overflow on add and subtract
        send_op(c8eu_pkg::CMD_LDA, 8'h7f, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_CLC, 8'h00, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_ADC, 8'h01, 1'b0, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_SBC, 8'h01, 1'b0, c8eu_pkg::BR_CC);
        // shift target flag only matters for shifts
        send_op(c8eu_pkg::CMD_ROR, 8'h01, 1'b1, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_ROL, 8'h80, 1'b1, c8eu_pkg::BR_CC);
        send_op(c8eu_pkg::CMD_LDY, 8'h00, 1'b1, c8eu_pkg::BR_CC);
        for (int b = c8eu_pkg::BR_CC; b <= c8eu_pkg::BR_VS; b++)
            send_op(c8eu_pkg::CMD_BRT, 8'hff, 1'b0, 3'(b));
        send_op(CMD_UNUSED_LO, 8'hff, 1'b1, c8eu_pkg::BR_VS);
        send_op(CMD_UNUSED_HI, 8'h55, 1'b0, c8eu_pkg::BR_CC);
    endtask

    task automatic test_random_with_idling(input int count);
        for (int k = 0; k < count; k++) begin
            // some stretches run without any idling
            if (k % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            send_random_op();
        end
    endtask

    task automatic test_drain_and_refill(input int bursts);
        idle_on = 1'b1;
        for (int b = 0; b < bursts; b++) begin
            repeat ($urandom_range(20, 60)) send_random_op();
            // hold input until every result is back
            i_valid <= 1'b0;
            wait_for_results();
        end
    endtask

    task automatic test_random_full_rate(input int count);
        idle_on = 1'b0;
        repeat (count) send_random_op();
    endtask

    initial begin
        int codes_hit;
        clear_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b1;
        test_every_operation();
        test_special_cases();
        test_random_with_idling(700);
        test_drain_and_refill(6);
        test_random_full_rate(500);

        i_valid <= 1'b0;
        wait_for_results();
        repeat (RESULT_LATENCY + 3) @(posedge i_clk);

        codes_hit = 0;
        for (int c = 0; c < 64; c++)
            codes_hit += cmd_seen[c];
        $display("Ran %0d operations over %0d of 64 command codes with idle and stall bursts,",
                 ops_sent, codes_hit);
        $display("checked %0d results field by field, %0d mismatches.",
                 results_checked, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
sv/c8eu_pkg.sv
sv/cpu8_execute_unit_with_flags.sv
verif/cpu8_execute_unit_with_flags_tb.sv
